// ----- design/skf3_pkg.sv -----
// Types and constants shared by the three-axis scalar Kalman filter core.
// No dependencies; used by skf3_ctrl, skf3_dpath and the top level.
package skf3_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_W     = 24;
    localparam int AXIS_W    = 2;
    localparam int NUM_AXES  = 3;
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;
    localparam int RES_W     = DATA_W + 1;
    localparam int DEN_W     = DATA_W + 1;
    localparam int REM_W     = DATA_W + 2;
    localparam int SUM_W     = DATA_W + 3;

    localparam logic [AXIS_W-1:0] AXIS_LATERAL = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_X       = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Y       = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE    = 2'd3;

    localparam logic ACTION_RESTART = 1'b0;
    localparam logic ACTION_MEASURE = 1'b1;

    localparam int REG_LAT_Q = 0;
    localparam int REG_LAT_R = 1;
    localparam int REG_X_Q   = 2;
    localparam int REG_X_R   = 3;
    localparam int REG_Y_Q   = 4;
    localparam int REG_Y_R   = 5;

    typedef struct packed {
        logic                     action;
        logic [AXIS_W-1:0]        axis;
        logic signed [DATA_W-1:0] measurement;
    } in_item_t;

    typedef struct packed {
        logic [AXIS_W-1:0]        axis_out;
        logic signed [DATA_W-1:0] estimate;
        logic [DATA_W-1:0]        predicted_covariance;
        logic [DATA_W-1:0]        covariance;
        logic                     saturated;
    } out_item_t;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] noise_bank_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic mul_step;
        logic finish;
        logic commit;
    } cmd_t;

endpackage

// ----- design/skf3_ctrl.sv -----
// Sequencer for the three-axis Kalman core: accepts items, steps the datapath
// through divide and multiply passes, and owns the result valid flag. Uses skf3_pkg.
module skf3_ctrl
    import skf3_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output cmd_t     cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_item.axis == AXIS_NONE) begin
                        state_next = ST_IDLE;
                    end else if (s_item.action == ACTION_RESTART) begin
                        state_next = ST_COMMIT;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTH
    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result committed over an untaken item");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.prep, cmd.div_step, cmd.mul_step, cmd.finish, cmd.commit}))
        else $error("more than one datapath command");

    a_measure_to_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.action == ACTION_MEASURE && s_item.axis != AXIS_NONE)
        |=> state_reg == ST_PREP)
        else $error("measurement item did not start preparation");

    a_div_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == CNT_LAST) |=> (state_reg == ST_MUL && cnt_reg == '0))
        else $error("divide pass did not hand over to multiply");
`endif

endmodule

// ----- design/skf3_dpath.sv -----
// Datapath of the three-axis Kalman core: per-axis state, bit-serial gain divider,
// shift-add multipliers and the result register. Uses skf3_pkg; driven by skf3_ctrl.
module skf3_dpath
    import skf3_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  in_item_t    s_item,
    input  noise_bank_t noise,
    output out_item_t   m_item
);

    localparam int KW  = FRAC_BITS + 1;
    localparam int AW1 = RES_W + KW;
    localparam int AW2 = DATA_W + KW;
    localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0] est_reg [NUM_AXES];
    logic [DATA_W-1:0]        cov_reg [NUM_AXES];

    logic [AXIS_W-1:0]        axis_reg;
    logic                     action_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [RES_W-1:0]  res_reg;
    logic [DATA_W-1:0]        pp_reg;
    logic                     sat_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     den_zero_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [KW-1:0]            k_reg;
    logic signed [AW1-1:0]    acc1_reg;
    logic [AW2-1:0]           acc2_reg;
    logic signed [DATA_W-1:0] xn_reg;
    logic [DATA_W-1:0]        pnew_reg;
    out_item_t                m_item_reg;

    logic signed [DATA_W-1:0] x_sel;
    logic [DATA_W-1:0]        cov_sel;
    logic [REG_W-1:0]         q_in_sel;
    logic [REG_W-1:0]         r_sel;
    logic [DATA_W:0]          pp_sum;
    logic [REM_W:0]           trial;
    logic                     q_bit;
    logic                     k_msb;
    logic signed [AW1-1:0]    prod_shift;
    logic signed [SUM_W-1:0]  xsum;
    logic                     x_ovf;
    logic [AW2-1:0]           pdiff;

    always_comb begin
        unique case (s_item.axis)
            AXIS_LATERAL: begin
                x_sel    = est_reg[0];
                cov_sel  = cov_reg[0];
                q_in_sel = noise[REG_LAT_Q];
            end
            AXIS_X: begin
                x_sel    = est_reg[1];
                cov_sel  = cov_reg[1];
                q_in_sel = noise[REG_X_Q];
            end
            default: begin
                x_sel    = est_reg[2];
                cov_sel  = cov_reg[2];
                q_in_sel = noise[REG_Y_Q];
            end
        endcase
    end

    always_comb begin
        unique case (axis_reg)
            AXIS_LATERAL: r_sel = noise[REG_LAT_R];
            AXIS_X:       r_sel = noise[REG_X_R];
            default:      r_sel = noise[REG_Y_R];
        endcase
    end

    assign pp_sum = {1'b0, cov_sel} + {{(DATA_W + 1 - REG_W){1'b0}}, q_in_sel};

    assign trial = {1'b0, rem_reg} - {2'b00, den_reg};
    assign q_bit = !trial[REM_W] && !den_zero_reg;
    assign k_msb = k_reg[KW-1];

    assign prod_shift = acc1_reg >>> FRAC_BITS;
    assign xsum  = {{(SUM_W - DATA_W){x_reg[DATA_W-1]}}, x_reg} + prod_shift[SUM_W-1:0];
    assign x_ovf = !((xsum[SUM_W-1:DATA_W-1] == '0) || (xsum[SUM_W-1:DATA_W-1] == '1));
    assign pdiff = {1'b0, pp_reg, {FRAC_BITS{1'b0}}} - acc2_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            axis_reg   <= s_item.axis;
            action_reg <= s_item.action;
            x_reg      <= x_sel;
            res_reg    <= {s_item.measurement[DATA_W-1], s_item.measurement}
                          - {x_sel[DATA_W-1], x_sel};
            pp_reg     <= pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];
            sat_reg    <= pp_sum[DATA_W];
        end
        if (cmd.prep) begin
            den_reg      <= {1'b0, pp_reg} + {{(DEN_W - REG_W){1'b0}}, r_sel};
            den_zero_reg <= (pp_reg == '0) && (r_sel == '0);
            rem_reg      <= {2'b00, pp_reg};
            k_reg        <= '0;
            acc1_reg     <= '0;
            acc2_reg     <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= q_bit ? {trial[REM_W-2:0], 1'b0} : {rem_reg[REM_W-2:0], 1'b0};
            k_reg   <= {k_reg[KW-2:0], q_bit};
        end
        if (cmd.mul_step) begin
            acc1_reg <= (acc1_reg <<< 1)
                        + (k_msb ? {{(AW1 - RES_W){res_reg[RES_W-1]}}, res_reg} : '0);
            acc2_reg <= (acc2_reg << 1)
                        + (k_msb ? {{(AW2 - DATA_W){1'b0}}, pp_reg} : '0);
            k_reg    <= {k_reg[KW-2:0], 1'b0};
        end
        if (cmd.finish) begin
            if (x_ovf) begin
                xn_reg <= xsum[SUM_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                        : {1'b0, {(DATA_W - 1){1'b1}}};
            end else begin
                xn_reg <= xsum[DATA_W-1:0];
            end
            sat_reg  <= sat_reg | x_ovf;
            pnew_reg <= pdiff[FRAC_BITS +: DATA_W];
        end
        if (cmd.commit) begin
            m_item_reg.axis_out <= axis_reg;
            if (action_reg == ACTION_RESTART) begin
                m_item_reg.estimate             <= '0;
                m_item_reg.predicted_covariance <= '0;
                m_item_reg.covariance           <= ONE_FX;
                m_item_reg.saturated            <= 1'b0;
            end else begin
                m_item_reg.estimate             <= xn_reg;
                m_item_reg.predicted_covariance <= pp_reg;
                m_item_reg.covariance           <= pnew_reg;
                m_item_reg.saturated            <= sat_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                est_reg[i] <= '0;
                cov_reg[i] <= ONE_FX;
            end
        end else if (cmd.commit) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (axis_reg == AXIS_W'(i)) begin
                    if (action_reg == ACTION_RESTART) begin
                        est_reg[i] <= '0;
                        cov_reg[i] <= ONE_FX;
                    end else begin
                        est_reg[i] <= xn_reg;
                        cov_reg[i] <= pnew_reg;
                    end
                end
            end
        end
    end

    assign m_item = m_item_reg;

endmodule

// ----- design/scalar_kalman_three_axis_core.sv -----
// Three independent scalar Kalman filters (lateral, x, y) in fixed point with
// FRAC_BITS fraction bits. A measurement item passes through the prepare, divide,
// multiply, finish and commit states before the next item can be accepted: the gain
// comes from a restoring divider that makes one quotient bit a cycle, and the
// estimate and covariance products from two shift-add multipliers that take one
// gain bit a cycle. A restart item goes straight to the commit state; an item for
// axis code three is taken and gives no result.
// The result sits in an output register, so a new item is accepted while it waits.
module scalar_kalman_three_axis_core
    import skf3_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wr_data
);

    localparam int ONE_INT = 1 << FRAC_BITS;
    localparam int Q_RESET = (ONE_INT + 50) / 100;
    localparam int R_RESET = (ONE_INT + 5) / 10;

    noise_bank_t noise_reg;
    cmd_t        cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                noise_reg[i] <= (i % 2 == 0) ? REG_W'(Q_RESET) : REG_W'(R_RESET);
            end
        end else if (cfg_wr_en) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (cfg_index == REG_IDX_W'(i)) begin
                    noise_reg[i] <= cfg_wr_data;
                end
            end
        end
    end

    skf3_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    skf3_dpath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_item  (s_item),
        .noise   (noise_reg),
        .m_item  (m_item)
    );

endmodule

// ----- bench/skf3_filter_checker.sv -----
// Scoreboard for scalar_kalman_three_axis_core: keeps its own copy of the three
// axis filters and noise registers, predicts every result and checks it field by field.
// Depends on skf3_pkg for the item types and constants.
module skf3_filter_checker
    import skf3_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_item,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wr_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   checked
);

    localparam logic [63:0]      ONE_FX    = 64'd1 << FRAC_BITS;
    localparam logic [63:0]      P_MAX     = 64'hFFFF_FFFF;
    localparam logic [REG_W-1:0] Q_DEFAULT = REG_W'((ONE_FX + 64'd50) / 64'd100);
    localparam logic [REG_W-1:0] R_DEFAULT = REG_W'((ONE_FX + 64'd5) / 64'd10);
    localparam longint           EST_MAX   = 64'sd2147483647;
    localparam longint           EST_MIN   = -64'sd2147483648;

    logic [REG_W-1:0]         noise    [NUM_REGS];
    logic signed [DATA_W-1:0] axis_est [NUM_AXES];
    logic [DATA_W-1:0]        axis_cov [NUM_AXES];
    out_item_t                filter_results_due [$];
    int                       errs = 0;
    int                       seen = 0;

    function automatic out_item_t filter_step(input in_item_t it);
        out_item_t   r;
        logic [63:0] p_pred;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] p_upd;
        longint      est_old;
        longint      z;
        longint      innov;
        longint      est_new;
        int          a;
        r          = '0;
        a          = int'(it.axis);
        r.axis_out = it.axis;
        if (it.action == ACTION_RESTART) begin
            axis_est[a]  = '0;
            axis_cov[a]  = DATA_W'(ONE_FX);
            r.covariance = DATA_W'(ONE_FX);
            return r;
        end
        p_pred = 64'(axis_cov[a]) + 64'(noise[2*a]);
        if (p_pred > P_MAX) begin
            p_pred      = P_MAX;
            r.saturated = 1'b1;
        end
        den  = p_pred + 64'(noise[2*a+1]);
        gain = (den == 0) ? 64'd0 : (p_pred << FRAC_BITS) / den;
        if (gain > ONE_FX)
            gain = ONE_FX;
        est_old = axis_est[a];
        z       = it.measurement;
        innov   = z - est_old;
        est_new = est_old + ((longint'(gain) * innov) >>> FRAC_BITS);
        if (est_new > EST_MAX) begin
            est_new     = EST_MAX;
            r.saturated = 1'b1;
        end else if (est_new < EST_MIN) begin
            est_new     = EST_MIN;
            r.saturated = 1'b1;
        end
        p_upd = ((ONE_FX - gain) * p_pred) >> FRAC_BITS;
        axis_est[a]            = est_new[DATA_W-1:0];
        axis_cov[a]            = p_upd[DATA_W-1:0];
        r.estimate             = est_new[DATA_W-1:0];
        r.predicted_covariance = p_pred[DATA_W-1:0];
        r.covariance           = p_upd[DATA_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errs++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                noise[2*i]   = Q_DEFAULT;
                noise[2*i+1] = R_DEFAULT;
                axis_est[i]  = '0;
                axis_cov[i]  = DATA_W'(ONE_FX);
            end
            filter_results_due.delete();
        end else begin
            if (cfg_wr_en && cfg_index < NUM_REGS)
                noise[cfg_index] = cfg_wr_data;
            if (s_valid && s_ready && s_item.axis != AXIS_NONE)
                filter_results_due.push_back(filter_step(s_item));
            if (m_valid && m_ready) begin
                if (filter_results_due.size() == 0) begin
                    errs++;
                    $error("axis_out: expected no result, got %0d", m_item.axis_out);
                end else begin
                    want = filter_results_due.pop_front();
                    seen++;
                    compare_field("axis_out", want.axis_out, m_item.axis_out);
                    compare_field("estimate", want.estimate, m_item.estimate);
                    compare_field("predicted_covariance", want.predicted_covariance,
                                  m_item.predicted_covariance);
                    compare_field("covariance", want.covariance, m_item.covariance);
                    compare_field("saturated", want.saturated, m_item.saturated);
                end
            end
        end
        mismatches  <= errs;
        outstanding <= filter_results_due.size();
        checked     <= seen;
    end

endmodule

// ----- bench/tb_scalar_kalman_three_axis_core.sv -----
// Top of the bench for scalar_kalman_three_axis_core: drives items, noise writes
// and receiver stalls, and gives the verdict from skf3_filter_checker's counts.
// Depends on skf3_pkg, the core and skf3_filter_checker.
module tb_scalar_kalman_three_axis_core;
    import skf3_pkg::*;

    localparam int FRAC     = 16;
    localparam int SETTLE   = 50;
    localparam int WD_LIMIT = 2000;
    localparam int PHASES   = 5;
    localparam int PER_PHASE = 150;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_item_t             s_item      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    out_item_t            m_item;
    logic                 cfg_wr_en   = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index   = '0;
    logic [REG_W-1:0]     cfg_wr_data = '0;

    int mismatches;
    int outstanding;
    int checked;
    int send_idle  = 0;
    int recv_stall = 0;
    int items_sent = 0;
    int settings   = 1;
    int quiet      = 0;

    scalar_kalman_three_axis_core #(.FRAC_BITS(FRAC)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    skf3_filter_checker #(.FRAC_BITS(FRAC)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_item(input logic action, input logic [AXIS_W-1:0] axis,
                             input logic [DATA_W-1:0] z);
        in_item_t it;
        it.action      = action;
        it.axis        = axis;
        it.measurement = z;
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // hold the sender until every result is back, then let the core settle
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_noise(input int idx, input logic [REG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_IDX_W'(idx);
        cfg_wr_data <= value;
        @(posedge aclk);
    endtask

    task automatic program_noise();
        logic [REG_W-1:0] v;
        for (int i = 0; i < NUM_REGS; i++) begin
            case ($urandom_range(4))
                0: v = '0;
                1: v = '1;
                2: v = REG_W'($urandom);
                default: v = REG_W'($urandom_range(1, 32'h0002_0000));
            endcase
            write_noise(i, v);
        end
        write_noise($urandom_range(NUM_REGS, 2**REG_IDX_W - 1), REG_W'($urandom));
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    function automatic logic [DATA_W-1:0] pick_measurement();
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    initial begin
        logic [AXIS_W-1:0] ax;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_item(ACTION_MEASURE, AXIS_LATERAL, 32'h7FFF_FFFF);
        push_item(ACTION_MEASURE, AXIS_X, 32'h8000_0000);
        push_item(ACTION_MEASURE, AXIS_Y, 32'h0000_0000);
        push_item(ACTION_MEASURE, AXIS_LATERAL, 32'hFFFF_FFFF);
        push_item(ACTION_MEASURE, AXIS_LATERAL, 32'h0000_0001);
        push_item(ACTION_RESTART, AXIS_LATERAL, 32'h1234_5678);
        push_item(ACTION_MEASURE, AXIS_NONE, 32'hDEAD_BEEF);
        push_item(ACTION_RESTART, AXIS_NONE, 32'h0000_0000);
        push_item(ACTION_RESTART, AXIS_X, 32'hFFFF_FFFF);
        push_item(ACTION_MEASURE, AXIS_X, 32'h7FFF_FFFF);
        drain_results();

        write_noise(REG_LAT_Q, '1);
        write_noise(REG_LAT_R, '0);
        write_noise(REG_X_Q, '0);
        write_noise(REG_X_R, '0);
        write_noise(REG_Y_Q, '1);
        write_noise(REG_Y_R, '1);
        write_noise(NUM_REGS, '1);
        write_noise(NUM_REGS + 1, 24'hA5A5A5);
        cfg_wr_en <= 1'b0;
        settings++;

        push_item(ACTION_MEASURE, AXIS_X, 32'h0005_0000);
        push_item(ACTION_MEASURE, AXIS_X, 32'h7FFF_FFFF);
        push_item(ACTION_MEASURE, AXIS_X, 32'h8000_0000);
        push_item(ACTION_MEASURE, AXIS_LATERAL, 32'h8000_0000);
        push_item(ACTION_MEASURE, AXIS_LATERAL, 32'h7FFF_FFFF);
        push_item(ACTION_MEASURE, AXIS_Y, 32'h7FFF_FFFF);
        push_item(ACTION_MEASURE, AXIS_Y, 32'h7FFF_FFFF);
        push_item(ACTION_MEASURE, AXIS_Y, 32'h7FFF_FFFF);
        push_item(ACTION_MEASURE, AXIS_Y, 32'h8000_0000);
        push_item(ACTION_RESTART, AXIS_Y, 32'h5555_5555);
        push_item(ACTION_MEASURE, AXIS_Y, 32'h5555_5555);
        push_item(ACTION_RESTART, AXIS_X, 32'hAAAA_AAAA);
        push_item(ACTION_MEASURE, AXIS_X, 32'hFFFF_FFFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            program_noise();
            case (ph)
                1: begin send_idle = 60; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 60; end
                3: begin send_idle = 27; recv_stall = 27; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                if (n == PER_PHASE / 2)
                    drain_results();
                ax = ($urandom_range(99) < 4) ? AXIS_NONE : AXIS_W'($urandom_range(NUM_AXES - 1));
                push_item(($urandom_range(99) < 12) ? ACTION_RESTART : ACTION_MEASURE,
                          ax, pick_measurement());
            end
        end

        send_idle  = 0;
        recv_stall = 0;
        drain_results();
        $display("Sent %0d items and checked %0d filter results across %0d noise settings,",
                 items_sent, checked, settings);
        $display("with sender gaps and receiver stalls mixed in four ways.");
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
